>>> rtl/tsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types, widths and reset values for the touch sample qualifier.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int READS_PER_RUN_DEF = 5;
    localparam int DROP_EACH_END_DEF = 1;

    localparam int DATA_W       = 10;
    localparam int ERR_W        = 8;
    localparam int COEF_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int PROD_W       = DATA_W + 1 + COEF_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int FRAC_W       = 14;
    localparam int OFFSET_SHIFT = 10;
    localparam int POS_W        = ACC_W - FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AGREE_TOL = 3'd0,
        REG_X_GAIN    = 3'd1,
        REG_X_OFFSET  = 3'd2,
        REG_Y_GAIN    = 3'd3,
        REG_Y_OFFSET  = 3'd4,
        REG_X_LIMIT   = 3'd5,
        REG_Y_LIMIT   = 3'd6
    } cfg_reg_e;

    typedef enum logic [1:0] {
        RUN_X0 = 2'd0,
        RUN_Y0 = 2'd1,
        RUN_X1 = 2'd2,
        RUN_Y1 = 2'd3
    } run_e;

    typedef struct packed {
        logic        [ERR_W-1:0]  agree_tol;
        logic signed [COEF_W-1:0] x_gain;
        logic signed [COEF_W-1:0] x_offset;
        logic signed [COEF_W-1:0] y_gain;
        logic signed [COEF_W-1:0] y_offset;
        logic        [DATA_W-1:0] x_limit;
        logic        [DATA_W-1:0] y_limit;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        agree_tol: 8'd5,
        x_gain:    -16'sd12845,
        x_offset:  16'sd8130,
        y_gain:    -16'sd5424,
        y_offset:  16'sd4843,
        x_limit:   10'd480,
        y_limit:   10'd272
    };

    typedef struct packed {
        run_e              run;
        logic [DATA_W-1:0] mean;
    } mean_tok_t;

endpackage

>>> rtl/tsq_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_sorter
// Group position counter and insertion-sorted run store; hands a snapshot of
// each completed sorted run to the next stage.
// ----------------------------------------------------------------------------
module tsq_sorter #(
    parameter int READS_PER_RUN = tsq_pkg::READS_PER_RUN_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [tsq_pkg::DATA_W-1:0]                     sample,
    input  logic                                           first,
    output logic                                           run_valid,
    input  logic                                           run_ready,
    output tsq_pkg::run_e                                  run_id,
    output logic [READS_PER_RUN-1:0][tsq_pkg::DATA_W-1:0]  run_vals
);
    import tsq_pkg::*;

    localparam int IDX_W = $clog2(READS_PER_RUN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(READS_PER_RUN - 1);

    logic [IDX_W-1:0]                         idx_reg, idx_next;
    run_e                                     run_reg, run_next;
    logic [READS_PER_RUN-1:0][DATA_W-1:0]     store_reg, store_next;
    logic [READS_PER_RUN-1:0][DATA_W-1:0]     snap_reg;
    run_e                                     snap_run_reg;
    logic                                     snap_valid_reg;

    logic [IDX_W-1:0]                         cur_idx;
    run_e                                     cur_run;
    logic                                     accept;
    logic                                     last;
    logic [READS_PER_RUN-1:0]                 own_gt;
    logic [READS_PER_RUN-1:0]                 below_gt;
    logic [READS_PER_RUN-1:0][DATA_W-1:0]     below_val;

    assign in_ready = !snap_valid_reg || run_ready;
    assign accept   = in_valid && in_ready;
    assign cur_idx  = first ? '0 : idx_reg;
    assign cur_run  = first ? RUN_X0 : run_reg;
    assign last     = (cur_idx == LAST_IDX);

    // one insertion step: entries above the new sample move up by one
    always_comb
    begin
        below_gt     = '0;
        below_val[0] = sample;
        for (int j = 0; j < READS_PER_RUN; j++)
        begin
            own_gt[j] = store_reg[j] > sample;
        end
        for (int j = 1; j < READS_PER_RUN; j++)
        begin
            below_gt[j]  = store_reg[j-1] > sample;
            below_val[j] = store_reg[j-1];
        end
        for (int j = 0; j < READS_PER_RUN; j++)
        begin
            if (IDX_W'(j) < cur_idx && !own_gt[j])
            begin
                store_next[j] = store_reg[j];
            end
            else if (IDX_W'(j) <= cur_idx)
            begin
                store_next[j] = below_gt[j] ? below_val[j] : sample;
            end
            else
            begin
                store_next[j] = store_reg[j];
            end
        end
    end

    always_comb
    begin
        if (last)
        begin
            idx_next = '0;
            run_next = run_e'(cur_run + 2'd1);
        end
        else
        begin
            idx_next = cur_idx + IDX_W'(1);
            run_next = cur_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            run_reg        <= RUN_X0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                idx_reg <= idx_next;
                run_reg <= run_next;
            end
            if (accept && last)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (run_ready)
            begin
                snap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg <= store_next;
        end
        if (accept && last)
        begin
            snap_reg     <= store_next;
            snap_run_reg <= cur_run;
        end
    end

    assign run_valid = snap_valid_reg;
    assign run_id    = snap_run_reg;
    assign run_vals  = snap_reg;

endmodule

>>> rtl/tsq_run_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_run_mean
// Trimmed sum of a sorted run, then floored mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module tsq_run_mean #(
    parameter int READS_PER_RUN = tsq_pkg::READS_PER_RUN_DEF,
    parameter int DROP_EACH_END = tsq_pkg::DROP_EACH_END_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           run_valid,
    output logic                                           run_ready,
    input  tsq_pkg::run_e                                  run_id,
    input  logic [READS_PER_RUN-1:0][tsq_pkg::DATA_W-1:0]  run_vals,
    output logic                                           tok_valid,
    input  logic                                           tok_ready,
    output tsq_pkg::mean_tok_t                             tok
);
    import tsq_pkg::*;

    localparam bit TRIM_WIDE = (2 * DROP_EACH_END >= READS_PER_RUN);
    localparam int KEEP      = TRIM_WIDE ? 1 : READS_PER_RUN - 2 * DROP_EACH_END;
    localparam int LO        = TRIM_WIDE ? (READS_PER_RUN - 1) / 2 : DROP_EACH_END;
    localparam int SUM_W     = $clog2(KEEP * ((1 << DATA_W) - 1) + 1);
    localparam int DIV_SHIFT = SUM_W + $clog2(KEEP);
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((1 << DIV_SHIFT) + KEEP - 1) / KEEP);

    logic                       s_valid_reg;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    run_e                       s_run_reg;
    logic                       m_valid_reg;
    mean_tok_t                  tok_reg, tok_next;
    logic [SUM_W+MULT_W-1:0]    quot_full;
    logic                       m_load_ok;
    logic                       s_load_ok;

    assign m_load_ok = !m_valid_reg || tok_ready;
    assign s_load_ok = !s_valid_reg || m_load_ok;
    assign run_ready = s_load_ok;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < KEEP; k++)
        begin
            sum_next = sum_next + SUM_W'(run_vals[LO + k]);
        end
    end

    // exact floor division: the reciprocal carries enough extra bits
    assign quot_full     = (SUM_W + MULT_W)'(sum_reg) * (SUM_W + MULT_W)'(DIV_MULT);
    assign tok_next.run  = s_run_reg;
    assign tok_next.mean = quot_full[DIV_SHIFT +: DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_load_ok)
            begin
                s_valid_reg <= run_valid;
            end
            if (m_load_ok)
            begin
                m_valid_reg <= s_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_load_ok && run_valid)
        begin
            sum_reg   <= sum_next;
            s_run_reg <= run_id;
        end
        if (m_load_ok && s_valid_reg)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid = m_valid_reg;
    assign tok       = tok_reg;

endmodule

>>> rtl/tsq_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_position
// Keeps the run means of a group, checks agreement, calibrates both axes and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module tsq_position (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsq_pkg::cfg_t               cfg,
    input  logic                        tok_valid,
    output logic                        tok_ready,
    input  tsq_pkg::mean_tok_t          tok,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        valid_res,
    output logic [tsq_pkg::DATA_W-1:0]  x_pos,
    output logic [tsq_pkg::DATA_W-1:0]  y_pos,
    output logic [tsq_pkg::DATA_W-1:0]  raw_x,
    output logic [tsq_pkg::DATA_W-1:0]  raw_y
);
    import tsq_pkg::*;

    function automatic logic [DATA_W-1:0] clamp_pos(
        input logic signed [ACC_W-1:0] acc,
        input logic [DATA_W-1:0]       limit
    );
        logic [POS_W-1:0] pos;
        pos = acc[ACC_W-1:FRAC_W];
        if (acc[ACC_W-1])
        begin
            return '0;
        end
        else if (pos > POS_W'(limit))
        begin
            return limit;
        end
        else
        begin
            return pos[DATA_W-1:0];
        end
    endfunction

    logic [DATA_W-1:0]          fx_reg, fy_reg, sx_reg;

    logic                       b_valid_reg;
    logic [DATA_W-1:0]          b_rx_reg, b_ry_reg;
    logic                       b_ok_reg;

    logic                       c_valid_reg;
    logic signed [PROD_W-1:0]   c_px_reg, c_py_reg;
    logic [DATA_W-1:0]          c_rx_reg, c_ry_reg;
    logic                       c_ok_reg;

    logic                       out_valid_reg;
    logic                       valid_res_reg;
    logic [DATA_W-1:0]          x_pos_reg, y_pos_reg, raw_x_reg, raw_y_reg;

    logic                       d_load_ok, c_load_ok, b_load_ok;
    logic                       tok_take;
    logic                       final_run;
    logic [DATA_W:0]            sum_x, sum_y;
    logic [DATA_W-1:0]          diff_x, diff_y;
    logic                       ok_next;
    logic signed [ACC_W-1:0]    acc_x, acc_y;

    assign d_load_ok = !out_valid_reg || out_ready;
    assign c_load_ok = !c_valid_reg || d_load_ok;
    assign b_load_ok = !b_valid_reg || c_load_ok;
    assign tok_ready = b_load_ok;
    assign tok_take  = tok_valid && tok_ready;
    assign final_run = (tok.run == RUN_Y1);

    assign sum_x  = {1'b0, fx_reg} + {1'b0, sx_reg};
    assign sum_y  = {1'b0, fy_reg} + {1'b0, tok.mean};
    assign diff_x = (fx_reg >= sx_reg) ? fx_reg - sx_reg : sx_reg - fx_reg;
    assign diff_y = (fy_reg >= tok.mean) ? fy_reg - tok.mean : tok.mean - fy_reg;
    assign ok_next = (diff_x <= DATA_W'(cfg.agree_tol)) && (diff_y <= DATA_W'(cfg.agree_tol));

    // Q.14 accumulator: offset is Q.4, so it lines up after a 10-bit shift
    assign acc_x = ACC_W'(c_px_reg) + (ACC_W'(cfg.x_offset) <<< OFFSET_SHIFT);
    assign acc_y = ACC_W'(c_py_reg) + (ACC_W'(cfg.y_offset) <<< OFFSET_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg        <= '0;
            fy_reg        <= '0;
            sx_reg        <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tok_take)
            begin
                case (tok.run)
                    RUN_X0:  fx_reg <= tok.mean;
                    RUN_Y0:  fy_reg <= tok.mean;
                    RUN_X1:  sx_reg <= tok.mean;
                    default: ;
                endcase
            end
            if (b_load_ok)
            begin
                b_valid_reg <= tok_valid && final_run;
            end
            if (c_load_ok)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_load_ok)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_take && final_run)
        begin
            b_rx_reg <= sum_x[DATA_W:1];
            b_ry_reg <= sum_y[DATA_W:1];
            b_ok_reg <= ok_next;
        end
        if (c_load_ok && b_valid_reg)
        begin
            c_px_reg <= $signed({1'b0, b_rx_reg}) * cfg.x_gain;
            c_py_reg <= $signed({1'b0, b_ry_reg}) * cfg.y_gain;
            c_rx_reg <= b_rx_reg;
            c_ry_reg <= b_ry_reg;
            c_ok_reg <= b_ok_reg;
        end
        if (d_load_ok && c_valid_reg)
        begin
            valid_res_reg <= c_ok_reg;
            x_pos_reg     <= c_ok_reg ? clamp_pos(acc_x, cfg.x_limit) : '0;
            y_pos_reg     <= c_ok_reg ? clamp_pos(acc_y, cfg.y_limit) : '0;
            raw_x_reg     <= c_rx_reg;
            raw_y_reg     <= c_ry_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign x_pos     = x_pos_reg;
    assign y_pos     = y_pos_reg;
    assign raw_x     = raw_x_reg;
    assign raw_y     = raw_y_reg;

endmodule

>>> rtl/touch_sample_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_qualifier
// Trimmed-mean touch position filter with fixed-point calibration.
// ----------------------------------------------------------------------------
// Takes one raw sample request per clock. A group is 4*READS_PER_RUN samples
// (X, Y, X, Y runs); first=1 restarts the group. Each sample is insertion
// sorted into the run store in the cycle it is accepted, so the input never
// waits on the filter. One result per group: the edge that takes the last
// sample loads the snapshot, then the trimmed sum, reciprocal divide,
// agreement check, gain multiply and offset/clamp are registered in turn,
// the last into the output register that drives out_valid. The input stalls
// only when results back up into a full pipeline. Config writes are taken
// every cycle (cfg_ready is always high).
module touch_sample_qualifier #(
    parameter int READS_PER_RUN = tsq_pkg::READS_PER_RUN_DEF,
    parameter int DROP_EACH_END = tsq_pkg::DROP_EACH_END_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tsq_pkg::DATA_W-1:0]     sample,
    input  logic                           first,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           valid_res,
    output logic [tsq_pkg::DATA_W-1:0]     x_pos,
    output logic [tsq_pkg::DATA_W-1:0]     y_pos,
    output logic [tsq_pkg::DATA_W-1:0]     raw_x,
    output logic [tsq_pkg::DATA_W-1:0]     raw_y,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsq_pkg::COEF_W-1:0]     cfg_data
);
    import tsq_pkg::*;

    cfg_t                                   cfg_reg, cfg_next;
    logic                                   run_valid, run_ready;
    run_e                                   run_id;
    logic [READS_PER_RUN-1:0][DATA_W-1:0]   run_vals;
    logic                                   tok_valid, tok_ready;
    mean_tok_t                              tok;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_AGREE_TOL: cfg_next.agree_tol = cfg_data[ERR_W-1:0];
                REG_X_GAIN:    cfg_next.x_gain    = cfg_data;
                REG_X_OFFSET:  cfg_next.x_offset  = cfg_data;
                REG_Y_GAIN:    cfg_next.y_gain    = cfg_data;
                REG_Y_OFFSET:  cfg_next.y_offset  = cfg_data;
                REG_X_LIMIT:   cfg_next.x_limit   = cfg_data[DATA_W-1:0];
                REG_Y_LIMIT:   cfg_next.y_limit   = cfg_data[DATA_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsq_sorter #(
        .READS_PER_RUN (READS_PER_RUN)
    ) u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .first     (first),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .run_id    (run_id),
        .run_vals  (run_vals)
    );

    tsq_run_mean #(
        .READS_PER_RUN (READS_PER_RUN),
        .DROP_EACH_END (DROP_EACH_END)
    ) u_run_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .run_id    (run_id),
        .run_vals  (run_vals),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    tsq_position u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .raw_x     (raw_x),
        .raw_y     (raw_y)
    );

endmodule

>>> rtl/tsq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_checker
// Port-level checks for the touch sample qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module tsq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [tsq_pkg::DATA_W-1:0]     sample,
    input logic                           first,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           valid_res,
    input logic [tsq_pkg::DATA_W-1:0]     x_pos,
    input logic [tsq_pkg::DATA_W-1:0]     y_pos,
    input logic [tsq_pkg::DATA_W-1:0]     raw_x,
    input logic [tsq_pkg::DATA_W-1:0]     raw_y,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [tsq_pkg::COEF_W-1:0]     cfg_data
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(x_pos)
            && $stable(y_pos) && $stable(raw_x) && $stable(raw_y))
        else $error("result changed while stalled");

    // with the output register empty, the whole pipeline can drain
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input request blocked with empty output");

    // rejected groups report no screen position
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> x_pos == '0 && y_pos == '0)
        else $error("invalid result carries a position");

endmodule

bind touch_sample_qualifier tsq_checker u_tsq_checker (.*);
